>>> rtl/cmfs_pkg.sv
// ============================================================================
// Circle model fit and score: shared package
// Widths, codes, handshake structs and small helpers used by every file.
// ============================================================================
package cmfs_pkg;

   localparam int COORD_W  = 32;    // coordinate width, signed Q16.16
   localparam int TOL_W    = 48;    // tolerance register width
   localparam int ERR_W    = 64;    // squared error width
   localparam int WIDE_W   = 100;   // signed working width
   localparam int A_W      = 99;    // first operand and result of the shared unit
   localparam int B_W      = 68;    // second operand of the shared unit
   localparam int CNT_W    = 7;
   localparam int MUL_STEPS  = 34;
   localparam int DIV_STEPS  = 99;
   localparam int SQRT_STEPS = 34;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [TOL_W-1:0] TOL_RESET = 48'd42949673;
   localparam logic CSR_IDX_DET_TOL = 1'b0;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef struct packed {
      logic             start;
      iter_op_type      op;
      logic [A_W-1:0]   a;
      logic [B_W-1:0]   b;
   } iter_req_type;

   typedef struct packed {
      logic             done;
      logic [A_W-1:0]   res;
   } iter_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DET1,
      ST_DET2,
      ST_CHECK,
      ST_SQ,
      ST_NX1,
      ST_NX2,
      ST_NY1,
      ST_NY2,
      ST_DIVX,
      ST_DIVY,
      ST_DX,
      ST_DY,
      ST_ROOT,
      ST_ERR,
      ST_FINISH
   } seq_state_type;

   function automatic logic [WIDE_W-1:0] mag_of(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-1:0] u;
      u = v;
      return v[WIDE_W-1] ? (~u + WIDE_W'(1)) : u;
   endfunction

endpackage

>>> rtl/cmfs_if.sv
// ============================================================================
// Circle model fit and score: channel interfaces
// Request and response channels with valid/ready handshake.
// ============================================================================
interface cmfs_req_if import cmfs_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic signed [COORD_W-1:0]  first_x;
   logic signed [COORD_W-1:0]  first_y;
   logic signed [COORD_W-1:0]  second_x;
   logic signed [COORD_W-1:0]  second_y;
   logic signed [COORD_W-1:0]  third_x;
   logic signed [COORD_W-1:0]  third_y;

   modport source (output valid, func, first_x, first_y, second_x, second_y,
                   third_x, third_y, input ready);
   modport sink   (input valid, func, first_x, first_y, second_x, second_y,
                   third_x, third_y, output ready);
endinterface

interface cmfs_rsp_if import cmfs_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic                       fit_ok;
   logic signed [COORD_W-1:0]  centre_x;
   logic signed [COORD_W-1:0]  centre_y;
   logic [COORD_W-1:0]         radius_out;
   logic [ERR_W-1:0]           squared_error;

   modport source (output valid, fit_ok, centre_x, centre_y, radius_out,
                   squared_error, input ready);
   modport sink   (input valid, fit_ok, centre_x, centre_y, radius_out,
                   squared_error, output ready);
endinterface

>>> rtl/cmfs_iter.sv
// ============================================================================
// Circle model fit and score: shared iterative arithmetic unit
// Shift-add multiply, restoring divide with rounding, and digit-by-digit
// square root with rounding, one bit (or bit pair) per cycle.
// ============================================================================
module cmfs_iter import cmfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_req_type ureq,
   output iter_rsp_type ursp
);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   iter_op_type       op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [A_W-1:0]    a_ff, a_in;
   logic [A_W-1:0]    acc_ff, acc_in;
   logic [B_W-1:0]    b_ff, b_in;
   logic [B_W:0]      rem_ff, rem_in;
   logic [B_W:0]      shifted;
   logic [B_W:0]      trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in  = fin_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      shifted = '0;
      trial   = '0;
      if (!busy_ff) begin
         if (ureq.start) begin
            busy_in = 1'b1;
            fin_in  = 1'b0;
            op_in   = ureq.op;
            a_in    = ureq.a;
            b_in    = ureq.b;
            acc_in  = '0;
            rem_in  = '0;
            unique case (ureq.op)
               OP_MUL:  cnt_in = CNT_W'(MUL_STEPS);
               OP_DIV:  cnt_in = CNT_W'(DIV_STEPS);
               OP_SQRT: cnt_in = CNT_W'(SQRT_STEPS);
               default: cnt_in = CNT_W'(MUL_STEPS);
            endcase
         end
      end else if (fin_ff) begin
         // Round to nearest on the finished quotient or root.
         busy_in = 1'b0;
         fin_in  = 1'b0;
         done_in = 1'b1;
         if (op_ff == OP_DIV) begin
            if ({rem_ff[B_W-1:0], 1'b0} >= {1'b0, b_ff}) begin
               acc_in = acc_ff + A_W'(1);
            end
         end else if (op_ff == OP_SQRT) begin
            if (rem_ff > acc_ff[B_W:0]) begin
               acc_in = acc_ff + A_W'(1);
            end
         end
      end else begin
         cnt_in = cnt_ff - CNT_W'(1);
         unique case (op_ff)
            OP_DIV: begin
               shifted = {rem_ff[B_W-1:0], a_ff[A_W-1]};
               a_in    = {a_ff[A_W-2:0], 1'b0};
               if (shifted >= {1'b0, b_ff}) begin
                  rem_in = shifted - {1'b0, b_ff};
                  acc_in = {acc_ff[A_W-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  acc_in = {acc_ff[A_W-2:0], 1'b0};
               end
            end
            OP_SQRT: begin
               shifted = {rem_ff[B_W-2:0], a_ff[B_W-1:B_W-2]};
               trial   = {acc_ff[B_W-2:0], 2'b01};
               a_in    = {a_ff[A_W-3:0], 2'b00};
               if (shifted >= trial) begin
                  rem_in = shifted - trial;
                  acc_in = {acc_ff[A_W-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  acc_in = {acc_ff[A_W-2:0], 1'b0};
               end
            end
            default: begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = {a_ff[A_W-2:0], 1'b0};
               b_in = {1'b0, b_ff[B_W-1:1]};
            end
         endcase
         if (cnt_ff == CNT_W'(1)) begin
            if (op_ff == OP_MUL) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               fin_in = 1'b1;
            end
         end
      end
   end

   assign ursp.done = done_ff;
   assign ursp.res  = acc_ff;

endmodule

>>> rtl/cmfs_ctrl.sv
// ============================================================================
// Circle model fit and score: sequencer and model state
// Steps one word through determinant, centre, radius or score, issuing each
// multiply, divide and square root to the shared unit.
// ============================================================================
module cmfs_ctrl import cmfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [TOL_W-1:0]   det_tol,
   cmfs_req_if.sink           req,
   cmfs_rsp_if.source         rsp,
   output iter_req_type       ureq,
   input  iter_rsp_type       ursp
);

   seq_state_type                state_ff, state_in;
   logic                         issued_ff, issued_in;
   logic                         func_ff, func_in;
   logic [2:0]                   sq_k_ff, sq_k_in;
   logic signed [COORD_W-1:0]    px_ff [3];
   logic signed [COORD_W-1:0]    py_ff [3];
   logic signed [WIDE_W-1:0]     acc_ff, acc_in;
   logic signed [B_W-1:0]        det_ff, det_in;
   logic [ERR_W-1:0]             s1_ff, s1_in, s2_ff, s2_in;
   logic signed [ERR_W:0]        n1_ff, n1_in, n2_ff, n2_in;
   logic signed [A_W-1:0]        nx_ff, nx_in, ny_ff, ny_in;
   logic signed [COORD_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_W-1:0]           rad_ff, rad_in;
   logic                         ok_ff, ok_in;
   logic [ERR_W-1:0]             err_ff, err_in;
   logic                         ov_ff, ov_in;
   logic                         o_ok_ff, o_ok_in;
   logic signed [COORD_W-1:0]    o_cx_ff, o_cx_in, o_cy_ff, o_cy_in;
   logic [COORD_W-1:0]           o_rad_ff, o_rad_in;
   logic [ERR_W-1:0]             o_err_ff, o_err_in;

   logic signed [COORD_W:0]      abx, aby, bcx, bcy, dx, dy;
   logic signed [COORD_W-1:0]    sq_sel;
   logic signed [WIDE_W-1:0]     opa_s, opb_s, prod_s, sum_s;
   logic [WIDE_W-1:0]            opa_mag, opb_mag, det_mag;
   logic                         use_unit, neg;
   iter_op_type                  op_sel;
   logic                         eq_pts;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         ov_ff     <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         rad_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         ov_ff     <= ov_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         rad_ff    <= rad_in;
      end
      if (state_ff == ST_IDLE && req.valid) begin
         px_ff[0] <= req.first_x;
         py_ff[0] <= req.first_y;
         px_ff[1] <= req.second_x;
         py_ff[1] <= req.second_y;
         px_ff[2] <= req.third_x;
         py_ff[2] <= req.third_y;
      end
      func_ff  <= func_in;
      sq_k_ff  <= sq_k_in;
      acc_ff   <= acc_in;
      det_ff   <= det_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      ok_ff    <= ok_in;
      err_ff   <= err_in;
      o_ok_ff  <= o_ok_in;
      o_cx_ff  <= o_cx_in;
      o_cy_ff  <= o_cy_in;
      o_rad_ff <= o_rad_in;
      o_err_ff <= o_err_in;
   end

   assign abx = (COORD_W+1)'(px_ff[0]) - (COORD_W+1)'(px_ff[1]);
   assign aby = (COORD_W+1)'(py_ff[0]) - (COORD_W+1)'(py_ff[1]);
   assign bcx = (COORD_W+1)'(px_ff[1]) - (COORD_W+1)'(px_ff[2]);
   assign bcy = (COORD_W+1)'(py_ff[1]) - (COORD_W+1)'(py_ff[2]);
   assign dx  = (COORD_W+1)'(px_ff[0]) - (COORD_W+1)'(cx_ff);
   assign dy  = (COORD_W+1)'(py_ff[0]) - (COORD_W+1)'(cy_ff);

   assign eq_pts = (px_ff[0] == px_ff[1] && py_ff[0] == py_ff[1]) ||
                   (px_ff[0] == px_ff[2] && py_ff[0] == py_ff[2]) ||
                   (px_ff[1] == px_ff[2] && py_ff[1] == py_ff[2]);

   always_comb begin
      case (sq_k_ff)
         3'd0:    sq_sel = px_ff[0];
         3'd1:    sq_sel = py_ff[0];
         3'd2:    sq_sel = px_ff[1];
         3'd3:    sq_sel = py_ff[1];
         3'd4:    sq_sel = px_ff[2];
         default: sq_sel = py_ff[2];
      endcase
   end

   // Operand selection for the shared unit; signs are handled here.
   always_comb begin
      use_unit = 1'b1;
      op_sel   = OP_MUL;
      opa_s    = '0;
      opb_s    = '0;
      unique case (state_ff)
         ST_DET1: begin
            opa_s = WIDE_W'(abx);
            opb_s = WIDE_W'(bcy);
         end
         ST_DET2: begin
            opa_s = WIDE_W'(bcx);
            opb_s = WIDE_W'(aby);
         end
         ST_SQ: begin
            opa_s = WIDE_W'(sq_sel);
            opb_s = WIDE_W'(sq_sel);
         end
         ST_NX1: begin
            opa_s = WIDE_W'(n1_ff);
            opb_s = WIDE_W'(bcy);
         end
         ST_NX2: begin
            opa_s = WIDE_W'(n2_ff);
            opb_s = WIDE_W'(aby);
         end
         ST_NY1: begin
            opa_s = WIDE_W'(n2_ff);
            opb_s = WIDE_W'(abx);
         end
         ST_NY2: begin
            opa_s = WIDE_W'(n1_ff);
            opb_s = WIDE_W'(bcx);
         end
         ST_DIVX: begin
            op_sel = OP_DIV;
            opa_s  = WIDE_W'(nx_ff);
            opb_s  = WIDE_W'(det_ff) + WIDE_W'(det_ff);
         end
         ST_DIVY: begin
            op_sel = OP_DIV;
            opa_s  = WIDE_W'(ny_ff);
            opb_s  = WIDE_W'(det_ff) + WIDE_W'(det_ff);
         end
         ST_DX: begin
            opa_s = WIDE_W'(dx);
            opb_s = WIDE_W'(dx);
         end
         ST_DY: begin
            opa_s = WIDE_W'(dy);
            opb_s = WIDE_W'(dy);
         end
         ST_ROOT: begin
            op_sel = OP_SQRT;
            opa_s  = acc_ff;
         end
         ST_ERR: begin
            opa_s = acc_ff;
            opb_s = acc_ff;
         end
         default: use_unit = 1'b0;
      endcase
   end

   assign opa_mag = mag_of(opa_s);
   assign opb_mag = mag_of(opb_s);
   assign neg     = opa_s[WIDE_W-1] ^ opb_s[WIDE_W-1];
   assign prod_s  = neg ? -$signed({1'b0, ursp.res}) : $signed({1'b0, ursp.res});
   assign sum_s   = acc_ff + prod_s;
   assign det_mag = mag_of(WIDE_W'(det_ff));

   assign ureq.start = use_unit && !issued_ff;
   assign ureq.op    = op_sel;
   assign ureq.a     = (op_sel == OP_SQRT) ? A_W'(opa_mag[B_W-1:0]) : opa_mag[A_W-1:0];
   assign ureq.b     = opb_mag[B_W-1:0];

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      func_in   = func_ff;
      sq_k_in   = sq_k_ff;
      acc_in    = acc_ff;
      det_in    = det_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      n1_in     = n1_ff;
      n2_in     = n2_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rad_in    = rad_ff;
      ok_in     = ok_ff;
      err_in    = err_ff;
      ov_in     = ov_ff;
      o_ok_in   = o_ok_ff;
      o_cx_in   = o_cx_ff;
      o_cy_in   = o_cy_ff;
      o_rad_in  = o_rad_ff;
      o_err_in  = o_err_ff;

      if (rsp.valid && rsp.ready) begin
         ov_in = 1'b0;
      end
      if (use_unit && !issued_ff) begin
         issued_in = 1'b1;
      end
      if (use_unit && ursp.done) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               issued_in = 1'b0;
               state_in = req.func ? ST_DX : ST_DET1;
            end
         end
         ST_DET1: begin
            if (ursp.done) begin
               acc_in   = prod_s;
               state_in = ST_DET2;
            end
         end
         ST_DET2: begin
            if (ursp.done) begin
               det_in   = B_W'(acc_ff - prod_s);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (eq_pts || det_ff == '0 || det_mag < WIDE_W'(det_tol)) begin
               ok_in    = 1'b0;
               err_in   = '0;
               state_in = ST_FINISH;
            end else begin
               sq_k_in  = 3'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (ursp.done) begin
               acc_in  = sq_k_ff[0] ? sum_s : prod_s;
               sq_k_in = sq_k_ff + 3'd1;
               if (sq_k_ff == 3'd1) begin
                  s1_in = sum_s[ERR_W-1:0];
               end
               if (sq_k_ff == 3'd3) begin
                  s2_in = sum_s[ERR_W-1:0];
               end
               if (sq_k_ff == 3'd5) begin
                  n1_in    = $signed({1'b0, s1_ff}) - $signed({1'b0, s2_ff});
                  n2_in    = $signed({1'b0, s2_ff}) - $signed({1'b0, sum_s[ERR_W-1:0]});
                  state_in = ST_NX1;
               end
            end
         end
         ST_NX1: begin
            if (ursp.done) begin
               acc_in   = prod_s;
               state_in = ST_NX2;
            end
         end
         ST_NX2: begin
            if (ursp.done) begin
               nx_in    = A_W'(acc_ff - prod_s);
               state_in = ST_NY1;
            end
         end
         ST_NY1: begin
            if (ursp.done) begin
               acc_in   = prod_s;
               state_in = ST_NY2;
            end
         end
         ST_NY2: begin
            if (ursp.done) begin
               ny_in    = A_W'(acc_ff - prod_s);
               state_in = ST_DIVX;
            end
         end
         ST_DIVX, ST_DIVY: begin
            if (ursp.done) begin
               // Saturate the rounded quotient magnitude to the coordinate range.
               if (neg) begin
                  cx_in = (ursp.res >= A_W'(COORD_MAX) + A_W'(1)) ? COORD_MIN :
                          -$signed(ursp.res[COORD_W-1:0]);
               end else begin
                  cx_in = (ursp.res > A_W'(COORD_MAX)) ? COORD_MAX :
                          $signed(ursp.res[COORD_W-1:0]);
               end
               if (state_ff == ST_DIVY) begin
                  cy_in    = cx_in;
                  cx_in    = cx_ff;
                  state_in = ST_DX;
               end else begin
                  state_in = ST_DIVY;
               end
            end
         end
         ST_DX: begin
            if (ursp.done) begin
               acc_in   = prod_s;
               state_in = ST_DY;
            end
         end
         ST_DY: begin
            if (ursp.done) begin
               acc_in   = sum_s;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (ursp.done) begin
               ok_in  = 1'b1;
               err_in = '0;
               if (func_ff) begin
                  acc_in   = WIDE_W'(ursp.res) - WIDE_W'(rad_ff);
                  state_in = ST_ERR;
               end else begin
                  rad_in   = (|ursp.res[A_W-1:COORD_W]) ? '1 : ursp.res[COORD_W-1:0];
                  state_in = ST_FINISH;
               end
            end
         end
         ST_ERR: begin
            if (ursp.done) begin
               err_in   = (|ursp.res[A_W-1:ERR_W]) ? '1 : ursp.res[ERR_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!ov_ff || rsp.ready) begin
               ov_in    = 1'b1;
               o_ok_in  = ok_ff;
               o_cx_in  = cx_ff;
               o_cy_in  = cy_ff;
               o_rad_in = rad_ff;
               o_err_in = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = ov_ff;
   assign rsp.fit_ok        = o_ok_ff;
   assign rsp.centre_x      = o_cx_ff;
   assign rsp.centre_y      = o_cy_ff;
   assign rsp.radius_out    = o_rad_ff;
   assign rsp.squared_error = o_err_ff;

endmodule

>>> rtl/circle_model_fit_and_score_top.sv
// ============================================================================
// Circle model fit and score: top level
// Configuration register port, sequencer and shared arithmetic unit.
// ============================================================================
// The block holds one circle model and handles one word at a time: a fit word
// (func 0) recomputes the circumcircle of three points, a score word (func 1)
// returns the squared radial error of the first point. Every multiply, divide
// and square root goes through one shared bit-serial unit; a refused fit ends
// after the determinant. The request side is ready only between words, while
// a finished response may still wait in its output register. Tolerance is
// written through the 64-bit register port at byte address 0.
module circle_model_fit_and_score_top import cmfs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   cmfs_req_if.sink               req_ch,
   cmfs_rsp_if.source             rsp_ch,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [TOL_W-1:0]  tol_ff, tol_in;
   iter_req_type      ureq;
   iter_rsp_type      ursp;
   logic              sel_tol;

   assign sel_tol = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_DET_TOL);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   always_comb begin
      tol_in = tol_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_tol) begin
         tol_in = csr_pwdata[TOL_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_tol ? CSR_DATA_W'(tol_ff) : '0;

   cmfs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .det_tol (tol_ff),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .ureq    (ureq),
      .ursp    (ursp)
   );

   cmfs_iter u_iter (
      .clock (clock),
      .reset (reset),
      .ureq  (ureq),
      .ursp  (ursp)
   );

endmodule

>>> tb/cmfs_tb_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// Circle model fit and score: testbench constants
// Operation codes and register addresses shared by the checker and the top.
// ============================================================================
package cmfs_tb_pkg;
   import cmfs_pkg::*;

   localparam logic FUNC_FIT   = 1'b0;
   localparam logic FUNC_SCORE = 1'b1;

   // The tolerance register is 48 bits wide on a 64-bit port, so registers sit 8 bytes apart.
   localparam logic [CSR_ADDR_W-1:0] ADDR_DET_TOL = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED  = CSR_ADDR_W'(8);

   localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;
endpackage

>>> tb/cmfs_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Circle model fit and score: result checker
// Predicts every response word from the accepted request words with exact
// wide integer arithmetic and compares the responses field by field.
// ============================================================================
module cmfs_checker import cmfs_pkg::*, cmfs_tb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   cmfs_req_if                    req_ch,
   cmfs_rsp_if                    rsp_ch,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int                     fail_count,
   output int                     pending
);
   typedef logic signed [191:0] wide_type;

   typedef struct {
      logic                       fit_ok;
      logic signed [COORD_W-1:0]  centre_x;
      logic signed [COORD_W-1:0]  centre_y;
      logic [COORD_W-1:0]         radius;
      logic [ERR_W-1:0]           sq_error;
   } circle_result_type;

   circle_result_type         expected_results[$];
   logic [TOL_W-1:0]          tolerance;
   logic signed [COORD_W-1:0] centre_x;
   logic signed [COORD_W-1:0] centre_y;
   logic [COORD_W-1:0]        radius;

   // Square root of a nonnegative value, rounded to nearest.
   function automatic logic [63:0] round_sqrt(wide_type s);
      logic [63:0] r;
      wide_type t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= s) r = r | (64'd1 << b);
      end
      t = r;
      if (t * t + t < s) r = r + 1;
      return r;
   endfunction

   function automatic logic [63:0] distance(wide_type dx, wide_type dy);
      return round_sqrt(dx * dx + dy * dy);
   endfunction

   // Quotient rounded half away from zero, saturated to a coordinate.
   function automatic logic signed [COORD_W-1:0] centre_div(wide_type n, wide_type d);
      wide_type nm, dm, q, rm, lim, res;
      nm = n < 0 ? -n : n;
      dm = d < 0 ? -d : d;
      q = nm / dm;
      rm = nm % dm;
      if (2 * rm >= dm) q = q + 1;
      lim = 1;
      lim = lim <<< (COORD_W - 1);
      if ((n < 0) != (d < 0)) begin
         if (q >= lim) return COORD_MIN;
         res = -q;
         return res[COORD_W-1:0];
      end
      if (q > lim - 1) return COORD_MAX;
      return q[COORD_W-1:0];
   endfunction

   function automatic void fit_circle(logic signed [COORD_W-1:0] p[6], output logic ok);
      wide_type ax, ay, bx, by, cx, cy, abx, aby, bcx, bcy, det, dmag, tol;
      wide_type n1, n2, nx, ny, r;
      ax = p[0]; ay = p[1]; bx = p[2]; by = p[3]; cx = p[4]; cy = p[5];
      ok = 1'b0;
      if ((ax == bx && ay == by) || (ax == cx && ay == cy) || (bx == cx && by == cy))
         return;
      abx = ax - bx; aby = ay - by; bcx = bx - cx; bcy = by - cy;
      det = abx * bcy - bcx * aby;
      dmag = det < 0 ? -det : det;
      tol = tolerance;
      if (det == 0 || dmag < tol) return;
      n1 = (ax * ax + ay * ay) - (bx * bx + by * by);
      n2 = (bx * bx + by * by) - (cx * cx + cy * cy);
      nx = n1 * bcy - n2 * aby;
      ny = n2 * abx - n1 * bcx;
      centre_x = centre_div(nx, 2 * det);
      centre_y = centre_div(ny, 2 * det);
      r = distance(wide_type'(centre_x) - ax, wide_type'(centre_y) - ay);
      radius = r > 64'hFFFF_FFFF ? '1 : r[COORD_W-1:0];
      ok = 1'b1;
   endfunction

   function automatic circle_result_type predict_word();
      circle_result_type res;
      logic signed [COORD_W-1:0] p[6];
      wide_type e, sq, px, py;
      p = '{req_ch.first_x, req_ch.first_y, req_ch.second_x, req_ch.second_y,
            req_ch.third_x, req_ch.third_y};
      res.fit_ok = 1'b1;
      res.sq_error = '0;
      if (req_ch.func == FUNC_FIT) begin
         fit_circle(p, res.fit_ok);
      end else begin
         px = p[0];
         py = p[1];
         e = distance(px - wide_type'(centre_x), py - wide_type'(centre_y));
         e = e - wide_type'({1'b0, radius});
         sq = e * e;
         res.sq_error = (sq >>> 64) != 0 ? '1 : sq[63:0];
      end
      res.centre_x = centre_x;
      res.centre_y = centre_y;
      res.radius = radius;
      return res;
   endfunction

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending = expected_results.size();

   always @(posedge clock) begin
      circle_result_type want;
      if (reset) begin
         tolerance = TOL_RESET;
         centre_x = '0;
         centre_y = '0;
         radius = '0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_DET_TOL)
            tolerance = csr_pwdata[TOL_W-1:0];
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               // A response word arrived with nothing outstanding.
               report("response valid", 64'd1, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.fit_ok !== want.fit_ok)
                  report("fit_ok", rsp_ch.fit_ok, want.fit_ok);
               if (rsp_ch.centre_x !== want.centre_x)
                  report("centre_x", rsp_ch.centre_x, want.centre_x);
               if (rsp_ch.centre_y !== want.centre_y)
                  report("centre_y", rsp_ch.centre_y, want.centre_y);
               if (rsp_ch.radius_out !== want.radius)
                  report("radius_out", rsp_ch.radius_out, want.radius);
               if (rsp_ch.squared_error !== want.sq_error)
                  report("squared_error", rsp_ch.squared_error, want.sq_error);
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(predict_word());
      end
   end
endmodule

>>> tb/circle_model_fit_and_score_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Circle model fit and score: testbench top
// Drives fit and score words and tolerance writes, with random idling on both
// channels, and gives the verdict from the checker's failure count or a stall limit.
// ============================================================================
module circle_model_fit_and_score_top_tb import cmfs_pkg::*, cmfs_tb_pkg::*;;
   localparam int STALL_LIMIT = 6000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  quiet;
   int                    fail_count;
   int                    pending;
   int                    idle_cycles;

   cmfs_req_if req_ch();
   cmfs_rsp_if rsp_ch();

   circle_model_fit_and_score_top u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   cmfs_checker u_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Response side: random stall bursts unless the run is in its quiet part.
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && stall == 0 && $urandom_range(0, 7) == 0)
            stall = $urandom_range(1, 4);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            stall--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_word(logic func, logic signed [COORD_W-1:0] p[6]);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.func = func;
      req_ch.first_x = p[0];
      req_ch.first_y = p[1];
      req_ch.second_x = p[2];
      req_ch.second_y = p[3];
      req_ch.third_x = p[4];
      req_ch.third_y = p[5];
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_ch.valid = 1'b0;
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Signed value within about plus or minus 2^k.
   function automatic logic signed [COORD_W-1:0] spread(int k);
      logic signed [COORD_W-1:0] v;
      v = $urandom;
      return v >>> (31 - k);
   endfunction

   task automatic random_words(int count);
      logic signed [COORD_W-1:0] p[6];
      logic signed [COORD_W-1:0] ox, oy;
      int kind, k;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         k = $urandom_range(2, 30);
         ox = spread($urandom_range(2, 30));
         oy = spread($urandom_range(2, 30));
         for (int i = 0; i < 6; i++) p[i] = (i % 2 ? oy : ox) + spread(k);
         if (kind == 5) begin
            for (int i = 0; i < 6; i++) p[i] = $urandom;
         end else if (kind == 6) begin
            // Broken fits: a repeated point or three points on one line.
            if ($urandom_range(0, 1)) begin
               p[4] = p[0];
               p[5] = p[1];
            end else begin
               p[4] = 2 * p[2] - p[0];
               p[5] = 2 * p[3] - p[1];
            end
         end
         send_word(kind >= 7 ? FUNC_SCORE : FUNC_FIT, p);
      end
   endtask

   initial begin
      logic signed [COORD_W-1:0] m, x;
      quiet = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_FIT;
      req_ch.first_x = '0;
      req_ch.first_y = '0;
      req_ch.second_x = '0;
      req_ch.second_y = '0;
      req_ch.third_x = '0;
      req_ch.third_y = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      m = COORD_MAX;
      x = COORD_MIN;
      // Directed words under the reset tolerance.
      send_word(FUNC_SCORE, '{0, 0, 0, 0, 0, 0});
      send_word(FUNC_SCORE, '{x, x, 0, 0, 0, 0});
      send_word(FUNC_FIT, '{Q_ONE, 0, Q_ONE, 0, 0, Q_ONE});
      send_word(FUNC_FIT, '{Q_ONE, 0, 0, Q_ONE, Q_ONE, 0});
      send_word(FUNC_FIT, '{Q_ONE, 0, 0, Q_ONE, 0, Q_ONE});
      send_word(FUNC_FIT, '{0, 0, Q_ONE, 0, 2 * Q_ONE, 0});
      send_word(FUNC_FIT, '{0, 0, 1, 0, 0, 1});
      send_word(FUNC_FIT, '{Q_ONE, 0, 0, Q_ONE, -Q_ONE, 0});
      send_word(FUNC_SCORE, '{2 * Q_ONE, 0, 0, 0, 0, 0});
      send_word(FUNC_SCORE, '{0, Q_ONE, 0, 0, 0, 0});
      send_word(FUNC_FIT, '{m, m, x, m, x, x});
      send_word(FUNC_SCORE, '{m, x, 0, 0, 0, 0});
      send_word(FUNC_FIT, '{x, 0, 0, 1, m, 0});
      send_word(FUNC_SCORE, '{x, m, m, x, m, x});
      send_word(FUNC_FIT, '{m, x, x, m, 0, 0});
      send_word(FUNC_FIT, '{-1, -1, m, -1, -1, x});
      send_word(FUNC_SCORE, '{-1, -1, -1, -1, -1, -1});
      drain();

      // Writes to an unused address must leave the tolerance alone.
      csr_write(ADDR_UNUSED, '0);
      csr_write(ADDR_DET_TOL, '0);
      send_word(FUNC_FIT, '{0, 0, Q_ONE, Q_ONE, 3 * Q_ONE, 3 * Q_ONE});
      send_word(FUNC_FIT, '{0, 0, 1, 0, 0, 1});
      random_words(400);
      drain();

      csr_write(ADDR_DET_TOL, {16'd0, 48'hFFFF_FFFF_FFFF});
      send_word(FUNC_FIT, '{Q_ONE, 0, 0, Q_ONE, -Q_ONE, 0});
      random_words(400);
      drain();

      csr_write(ADDR_DET_TOL, {$urandom, $urandom});
      random_words(400);
      drain();

      csr_write(ADDR_DET_TOL, {16'd0, TOL_RESET});
      quiet = 1'b1;
      random_words(400);
      drain();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
